[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UER_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define UER_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/uer_pkg.sv]
// types, constants and register map of the ultrasonic echo ranger
// no dependencies
package uer_pkg;

    localparam int COUNTER_WIDTH_DEF = 19;
    localparam int CFG_DATA_W        = 19;
    localparam int CFG_INDEX_W       = 3;
    localparam int TICKS_W           = 19;
    localparam int TRIG_W            = 8;
    localparam int WIDTH_W           = 16;
    localparam int DIST_W            = 16;
    localparam int DIST_SHIFT        = 16;
    localparam int PROD_W            = 33;

    // centi-cm per tick scaled by 2^16
    localparam logic [16:0] DIST_SCALE = 17'd112493;

    localparam logic [TICKS_W-1:0] STARTUP_DEF   = 19'd300000;
    localparam logic [TRIG_W-1:0]  TRIGGER_DEF   = 8'd10;
    localparam logic [TICKS_W-1:0] RISE_TO_DEF   = 19'd30000;
    localparam logic [TICKS_W-1:0] HIGH_TO_DEF   = 19'd30000;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_DEF = 16'd50;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_DEF = 16'd30000;
    localparam logic [TICKS_W-1:0] GAP_DEF       = 19'd80000;
    localparam logic [DIST_W-1:0]  DEADBAND_DEF  = 16'd20;

    typedef enum logic [2:0] {
        PH_STARTUP = 3'd0,
        PH_TRIGGER = 3'd1,
        PH_RISE    = 3'd2,
        PH_HIGH    = 3'd3,
        PH_GAP     = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STARTUP   = 3'd0,
        REG_TRIGGER   = 3'd1,
        REG_RISE_TO   = 3'd2,
        REG_HIGH_TO   = 3'd3,
        REG_MIN_WIDTH = 3'd4,
        REG_MAX_WIDTH = 3'd5,
        REG_GAP       = 3'd6,
        REG_DEADBAND  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TICKS_W-1:0] startup_ticks;
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [TICKS_W-1:0] rise_timeout_ticks;
        logic [TICKS_W-1:0] high_timeout_ticks;
        logic [WIDTH_W-1:0] min_width_ticks;
        logic [WIDTH_W-1:0] max_width_ticks;
        logic [TICKS_W-1:0] gap_ticks;
        logic [DIST_W-1:0]  deadband_centi_cm;
    } uer_cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              new_reading;
        logic [DIST_W-1:0] measured_distance;
        logic              distance_changed;
        logic [DIST_W-1:0] reported_distance;
    } uer_result_t;

endpackage

[rtl/uer_step.sv]
// ranging sequencer: phase, tick counters and distance conversion per tick
// depends on uer_pkg
module uer_step
    import uer_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic        echo_level,
    input  uer_cfg_t    cfg,
    output uer_result_t result
);

    localparam int CMP_W = (COUNTER_WIDTH > TICKS_W) ? COUNTER_WIDTH : TICKS_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    phase_t                   phase_reg, phase_next, phase_eff;
    logic [COUNTER_WIDTH-1:0] tick_count_reg, tick_count_next, tick_eff;
    logic [COUNTER_WIDTH-1:0] pulse_width_reg, pulse_width_next;
    logic [DIST_W-1:0]        last_measured_reg, shown_distance_reg;

    logic                     idle_phase;
    logic                     idle_done;
    logic [TICKS_W-1:0]       idle_limit;
    logic [COUNTER_WIDTH-1:0] tick_inc;
    logic [COUNTER_WIDTH-1:0] width_inc;
    logic                     width_ok;
    logic [PROD_W-1:0]        product;
    logic [DIST_W:0]          dist_full;
    logic [DIST_W-1:0]        dist_sat;
    logic [DIST_W-1:0]        dist_diff;

    // startup and gap either count or fall through into the trigger
    always_comb
    begin
        idle_phase = (phase_reg != PH_TRIGGER) && (phase_reg != PH_RISE)
                  && (phase_reg != PH_HIGH);
        idle_limit = (phase_reg == PH_STARTUP) ? cfg.startup_ticks : cfg.gap_ticks;
        idle_done  = (CMP_W'(tick_count_reg) >= CMP_W'(idle_limit))
                  || (tick_count_reg == CNT_MAX);
        phase_eff  = phase_reg;
        tick_eff   = tick_count_reg;
        if (idle_phase)
        begin
            if (idle_done)
            begin
                phase_eff = PH_TRIGGER;
                tick_eff  = '0;
            end
            else
            begin
                tick_eff = tick_count_reg + COUNTER_WIDTH'(1);
            end
        end
        tick_inc  = (tick_eff == CNT_MAX) ? CNT_MAX : tick_eff + COUNTER_WIDTH'(1);
        width_inc = (pulse_width_reg == CNT_MAX) ? CNT_MAX
                  : pulse_width_reg + COUNTER_WIDTH'(1);
    end

    // next state
    always_comb
    begin
        phase_next       = phase_eff;
        tick_count_next  = tick_eff;
        pulse_width_next = pulse_width_reg;
        unique case (phase_eff)
            PH_TRIGGER:
            begin
                tick_count_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.trigger_ticks))
                begin
                    phase_next      = PH_RISE;
                    tick_count_next = '0;
                end
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    phase_next       = PH_HIGH;
                    pulse_width_next = COUNTER_WIDTH'(1);
                end
                else
                begin
                    tick_count_next = tick_inc;
                    if ((CMP_W'(tick_inc) > CMP_W'(cfg.rise_timeout_ticks))
                        || (tick_inc == CNT_MAX))
                    begin
                        phase_next      = PH_GAP;
                        tick_count_next = '0;
                    end
                end
            end
            PH_HIGH:
            begin
                if (echo_level)
                begin
                    pulse_width_next = width_inc;
                    if ((CMP_W'(width_inc) > CMP_W'(cfg.high_timeout_ticks))
                        || (width_inc == CNT_MAX))
                    begin
                        phase_next      = PH_GAP;
                        tick_count_next = '0;
                    end
                end
                else
                begin
                    phase_next      = PH_GAP;
                    tick_count_next = '0;
                end
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        width_ok  = (CMP_W'(pulse_width_reg) > CMP_W'(cfg.min_width_ticks))
                 && (CMP_W'(pulse_width_reg) < CMP_W'(cfg.max_width_ticks));
        product   = PROD_W'(pulse_width_reg[WIDTH_W-1:0]) * PROD_W'(DIST_SCALE);
        dist_full = product[DIST_SHIFT +: DIST_W+1];
        dist_sat  = dist_full[DIST_W] ? {DIST_W{1'b1}} : dist_full[DIST_W-1:0];
        dist_diff = (dist_sat > shown_distance_reg) ? dist_sat - shown_distance_reg
                  : shown_distance_reg - dist_sat;

        result.trigger_level     = 1'b0;
        result.new_reading       = 1'b0;
        result.distance_changed  = 1'b0;
        unique case (phase_eff)
            PH_TRIGGER:
            begin
                result.trigger_level = 1'b1;
            end
            PH_HIGH:
            begin
                if (!echo_level && width_ok)
                begin
                    result.new_reading      = 1'b1;
                    result.distance_changed = dist_diff > cfg.deadband_centi_cm;
                end
            end
            default:
            begin
                result.trigger_level = 1'b0;
            end
        endcase
        result.measured_distance = result.new_reading ? dist_sat : last_measured_reg;
        result.reported_distance = result.distance_changed ? dist_sat
                                 : shown_distance_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_STARTUP;
            tick_count_reg     <= '0;
            pulse_width_reg    <= '0;
            last_measured_reg  <= '0;
            shown_distance_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            pulse_width_reg    <= pulse_width_next;
            last_measured_reg  <= result.measured_distance;
            shown_distance_reg <= result.reported_distance;
        end
    end

endmodule

[rtl/uer_skid.sv]
// output register with one skid entry between the sequencer and the receiver
// depends on uer_pkg
module uer_skid
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  uer_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output uer_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    uer_result_t out_data_reg, out_data_next;
    uer_result_t skid_data_reg, skid_data_next;
    logic        pop;

    always_comb
    begin
        pop             = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/ultrasonic_echo_ranger.sv]
// top level of the ultrasonic echo ranger: config registers, sequencer, output buffer
// depends on uer_pkg, uer_step and uer_skid
//
// each input request is one 1 us tick carrying the sampled echo pin level;
// each accepted tick yields exactly one output request with the trigger pin
// level, a new-reading flag, the latest measured distance, a changed flag and
// the reported distance, both distances in 0.01 cm
// input is taken when in_valid is high and in_stall low; output is taken when
// out_valid is high and out_stall low
// each accepted tick's result is registered in the output register, or in the
// skid entry while a stalled output holds there; one tick per cycle is sustained
// while the skid entry is free, set by the combinational sequencer step with its
// 16x17 multiply; in_stall rises only while that entry is occupied
// config writes (cfg_valid, cfg_index, cfg_data) are always ready and take
// effect on the next tick; write them only while the block is idle
// reset restores default register values, returns to the startup wait with
// zero counters and distances, and empties the output buffer
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   echo_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   trigger_level,
    output logic                   new_reading,
    output logic [DIST_W-1:0]      measured_distance,
    output logic                   distance_changed,
    output logic [DIST_W-1:0]      reported_distance,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    uer_cfg_t    cfg_reg;
    uer_result_t step_result;
    uer_result_t out_data;
    logic        in_accept;
    logic        skid_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_full;
    assign in_accept = in_valid && !skid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_ticks      <= STARTUP_DEF;
            cfg_reg.trigger_ticks      <= TRIGGER_DEF;
            cfg_reg.rise_timeout_ticks <= RISE_TO_DEF;
            cfg_reg.high_timeout_ticks <= HIGH_TO_DEF;
            cfg_reg.min_width_ticks    <= MIN_WIDTH_DEF;
            cfg_reg.max_width_ticks    <= MAX_WIDTH_DEF;
            cfg_reg.gap_ticks          <= GAP_DEF;
            cfg_reg.deadband_centi_cm  <= DEADBAND_DEF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_STARTUP:   cfg_reg.startup_ticks      <= cfg_data[TICKS_W-1:0];
                REG_TRIGGER:   cfg_reg.trigger_ticks      <= cfg_data[TRIG_W-1:0];
                REG_RISE_TO:   cfg_reg.rise_timeout_ticks <= cfg_data[TICKS_W-1:0];
                REG_HIGH_TO:   cfg_reg.high_timeout_ticks <= cfg_data[TICKS_W-1:0];
                REG_MIN_WIDTH: cfg_reg.min_width_ticks    <= cfg_data[WIDTH_W-1:0];
                REG_MAX_WIDTH: cfg_reg.max_width_ticks    <= cfg_data[WIDTH_W-1:0];
                REG_GAP:       cfg_reg.gap_ticks          <= cfg_data[TICKS_W-1:0];
                REG_DEADBAND:  cfg_reg.deadband_centi_cm  <= cfg_data[DIST_W-1:0];
                default:       cfg_reg.gap_ticks          <= cfg_reg.gap_ticks;
            endcase
        end
    end

    uer_step #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_accept),
        .echo_level (echo_level),
        .cfg        (cfg_reg),
        .result     (step_result)
    );

    uer_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (step_result),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign trigger_level     = out_data.trigger_level;
    assign new_reading       = out_data.new_reading;
    assign measured_distance = out_data.measured_distance;
    assign distance_changed  = out_data.distance_changed;
    assign reported_distance = out_data.reported_distance;

endmodule

[rtl/uer_checker.sv]
// port-level checks of the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and assert_macros.svh
`include "assert_macros.svh"

module uer_checker
    import uer_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   new_reading,
    input logic [DIST_W-1:0]      measured_distance,
    input logic                   distance_changed,
    input logic [DIST_W-1:0]      reported_distance
);

    `UER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `UER_ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable(reported_distance))
    `UER_ASSERT_SAME(a_stall_needs_out, in_stall, out_valid)
    `UER_ASSERT_SAME(a_change_needs_reading, out_valid && distance_changed, new_reading)
    `UER_ASSERT_SAME(a_change_shows_reading, out_valid && distance_changed, reported_distance == measured_distance)

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (.*);
